### design/str_pkg.sv
// Shared constants, parameter-count table and pointer helper for the syscall trace recorder.
package str_pkg;

  localparam int RING_WORDS = 512;
  localparam int PTR_W      = $clog2(RING_WORDS);
  localparam int WORD_W     = 64;
  localparam int NUM_W      = 6;
  localparam int CNT_W      = 3;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TRACE_ENABLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_TRACE_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRACED_MASK     = 2'd2;

  // Operation codes
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Syscall number that is never recorded
  localparam logic [NUM_W-1:0] NUM_UNTRACED = 6'd38;

  // Parameter words that follow each syscall number
  localparam logic [CNT_W-1:0] PARAM_WORDS [64] = '{
    3'd0, 3'd1, 3'd0, 3'd0, 3'd2, 3'd3, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd0, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0,
    3'd4, 3'd2, 3'd3, 3'd1, 3'd0, 3'd0, 3'd0, 3'd2,
    3'd3, 3'd3, 3'd0, 3'd1, 3'd2, 3'd1, 3'd3, 3'd0,
    3'd0, 3'd0, 3'd0, 3'd4, 3'd1, 3'd2, 3'd0, 3'd3,
    3'd2, 3'd3, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0
  };

  // Count of parameter words after a stored head word; large words have none
  function automatic logic [CNT_W-1:0] param_count(input logic [WORD_W-1:0] word);
    logic [CNT_W-1:0] cnt;
    cnt = '0;
    if (word[WORD_W-1:NUM_W] == '0) begin
      cnt = PARAM_WORDS[word[NUM_W-1:0]];
    end
    return cnt;
  endfunction

  // Advance a ring pointer with wrap
  function automatic logic [PTR_W-1:0] ptr_advance(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] nxt;
    if (ptr == PTR_W'(RING_WORDS - 1)) begin
      nxt = '0;
    end else begin
      nxt = ptr + 1'b1;
    end
    return nxt;
  endfunction

endpackage

### design/syscall_trace_recorder.sv
// Top level of the syscall trace recorder: filter, word ring memory and readout sequencer.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------------
//   in      | input     | in_valid/in_stall  | opcode, syscall_number, arg_one .. arg_four
//   out     | output    | out_valid/out_stall| read_word, last_word, ring_empty
//   cfg     | input     | cfg_write          | cfg_index, cfg_data
//
// A traced record item writes its head word, then its parameter words, and stops early when the
// ring is or becomes full; an ignored record item leaves the sequencer idle. A read item first
// issues the ring read of its head word, then emits one word per cycle from the read port while
// the output is not stalled. An empty read returns a single zero word marked last. Reset
// clears pointers, full flag and configuration; the ring contents are not cleared. A stalled
// output holds the sequencer and the input stays stalled.
module syscall_trace_recorder
  import str_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // input channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 opcode,
  input  logic [NUM_W-1:0]     syscall_number,
  input  logic [WORD_W-1:0]    arg_one,
  input  logic [WORD_W-1:0]    arg_two,
  input  logic [WORD_W-1:0]    arg_three,
  input  logic [WORD_W-1:0]    arg_four,
  // output channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_W-1:0]    read_word,
  output logic                 last_word,
  output logic                 ring_empty,
  // configuration port
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_WRITE    = 5'b00010,
    ST_RD_REQ   = 5'b00100,
    ST_RD_EMIT  = 5'b01000,
    ST_RD_EMPTY = 5'b10000
  } str_state_t;

  str_state_t state;

  logic              trace_enable;
  logic              full_trace_mode;
  logic [WORD_W-1:0] traced_mask;

  logic [PTR_W-1:0]  write_pointer;
  logic [PTR_W-1:0]  read_pointer;
  logic              ring_full;

  logic [NUM_W-1:0]  rec_num;
  logic [WORD_W-1:0] rec_args [4];
  logic [CNT_W-1:0]  word_idx;
  logic [CNT_W-1:0]  word_cnt;
  logic              rd_first;
  logic [CNT_W-1:0]  rd_left;

  logic [WORD_W-1:0] ring_mem [RING_WORDS];
  logic [WORD_W-1:0] rd_data;
  logic [PTR_W-1:0]  rd_addr;

  logic              in_accept;
  logic              record_hit;
  logic              ring_is_empty;
  logic [PTR_W-1:0]  wp_adv;
  logic [PTR_W-1:0]  rp_adv;
  logic              wr_en;
  logic [WORD_W-1:0] wr_word;
  logic              out_free;
  logic              emit_load;
  logic              out_load;
  logic [CNT_W-1:0]  rd_count;

  assign in_stall      = (state != ST_IDLE);
  assign in_accept     = in_valid && !in_stall;
  assign record_hit    = trace_enable && (syscall_number != NUM_UNTRACED) &&
                         (full_trace_mode || traced_mask[syscall_number]);
  assign ring_is_empty = (read_pointer == write_pointer) && !ring_full;
  assign wp_adv        = ptr_advance(write_pointer);
  assign rp_adv        = ptr_advance(read_pointer);

  // Select the word to write: number first, then parameters
  assign wr_en   = (state == ST_WRITE) && !ring_full;
  assign wr_word = (word_idx == '0) ? {{(WORD_W-NUM_W){1'b0}}, rec_num}
                                    : rec_args[2'(word_idx - 1'b1)];

  // Emit one word when the output register is free
  assign out_free  = !out_valid || !out_stall;
  assign emit_load = (state == ST_RD_EMIT) && out_free;
  assign out_load  = emit_load || ((state == ST_RD_EMPTY) && out_free);
  assign rd_count  = rd_first ? param_count(rd_data) : rd_left;

  // Read ahead to the next entry when a word leaves, else re-read the current one
  assign rd_addr = emit_load ? rp_adv : read_pointer;

  // Ring memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[write_pointer] <= wr_word;
    end
    rd_data <= ring_mem[rd_addr];
  end

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      trace_enable    <= 1'b0;
      full_trace_mode <= 1'b0;
      traced_mask     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TRACE_ENABLE:    trace_enable    <= cfg_data[0];
        REG_FULL_TRACE_MODE: full_trace_mode <= cfg_data[0];
        REG_TRACED_MASK:     traced_mask     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Latch the record payload
  always_ff @(posedge clk) begin
    if (in_accept && (opcode == OP_RECORD)) begin
      rec_num     <= syscall_number;
      rec_args[0] <= arg_one;
      rec_args[1] <= arg_two;
      rec_args[2] <= arg_three;
      rec_args[3] <= arg_four;
      word_cnt    <= PARAM_WORDS[syscall_number];
    end
  end

  // Sequence writes and readout; advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      write_pointer <= '0;
      read_pointer  <= '0;
      ring_full     <= 1'b0;
      out_valid     <= 1'b0;
      word_idx      <= '0;
      rd_first      <= 1'b0;
      rd_left       <= '0;
    end else begin
      // Hold the output word until it is taken
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (opcode == OP_RECORD) begin
              word_idx <= '0;
              if (record_hit) begin
                state <= ST_WRITE;
              end
            end else if (ring_is_empty) begin
              state <= ST_RD_EMPTY;
            end else begin
              ring_full <= 1'b0;
              rd_first  <= 1'b1;
              state     <= ST_RD_REQ;
            end
          end
        end
        ST_WRITE: begin
          if (wr_en) begin
            write_pointer <= wp_adv;
            if (wp_adv == read_pointer) begin
              ring_full <= 1'b1;
            end
          end
          if (ring_full || (word_idx == word_cnt)) begin
            state <= ST_IDLE;
          end else begin
            word_idx <= word_idx + 1'b1;
          end
        end
        ST_RD_REQ: begin
          state <= ST_RD_EMIT;
        end
        ST_RD_EMIT: begin
          if (emit_load) begin
            read_pointer <= rp_adv;
            rd_first     <= 1'b0;
            rd_left      <= rd_count - 1'b1;
            if (rd_count == '0) begin
              state <= ST_IDLE;
            end
          end
        end
        ST_RD_EMPTY: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Load the output word register
  always_ff @(posedge clk) begin
    if (emit_load) begin
      read_word  <= rd_data;
      last_word  <= (rd_count == '0);
      ring_empty <= 1'b0;
    end else if ((state == ST_RD_EMPTY) && out_free) begin
      read_word  <= '0;
      last_word  <= 1'b1;
      ring_empty <= 1'b1;
    end
  end

endmodule

### design/str_checker.sv
// Port-level checker for the syscall trace recorder and its bind.
module str_checker
  import str_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 opcode,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [WORD_W-1:0]    read_word,
  input logic                 last_word,
  input logic                 ring_empty
);

  // An empty-ring result is a single zero word marked last
  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && ring_empty |-> last_word && (read_word == '0))
    else $error("empty result not a single zero word");

  // A read item keeps the input stalled while its words go out
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (opcode == OP_READ) |=> in_stall)
    else $error("input taken while a read is in progress");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_word) &&
                              $stable(last_word) && $stable(ring_empty))
    else $error("stalled output word changed");

  // Reset leaves no output word pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind syscall_trace_recorder str_checker u_str_checker (.*);

### sim/testbench.sv
// Self-checking testbench for the syscall trace recorder: random traffic, ring predictor, checks.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import str_pkg::*;

  // One expected output word of a read
  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic              is_last;
    logic              is_empty;
  } read_beat_t;

  typedef enum {RX_FLOW, RX_SPARSE, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  // Mirror of the trace ring; predicts the words that each read returns
  class trace_scoreboard;
    bit                trace_on;
    bit                trace_all;
    logic [WORD_W-1:0] trace_mask;
    logic [WORD_W-1:0] ring [RING_WORDS];
    int unsigned       wr_ptr;
    int unsigned       rd_ptr;
    bit                ring_full;
    read_beat_t        expected_words [$];
    int unsigned       failures;
    int unsigned       words_checked;
    int unsigned       items_seen;
    int unsigned       records_kept;
    int unsigned       words_dropped;
    int unsigned       reads_seen;
    int unsigned       empty_reads;

    function new();
      foreach (ring[i]) ring[i] = '0;
    endfunction

    // Parameter words that follow a head word; anything 64 or above has none
    function int unsigned arg_words(logic [WORD_W-1:0] head);
      if (head >= 64) return 0;
      case (head[NUM_W-1:0])
        1, 6, 7, 12, 14, 19, 27, 29, 36: return 1;
        4, 8, 9, 17, 23, 28, 37, 40:     return 2;
        5, 18, 24, 25, 30, 39, 41:       return 3;
        16, 35:                          return 4;
        default:                         return 0;
      endcase
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      case (idx)
        REG_TRACE_ENABLE:    trace_on = data[0];
        REG_FULL_TRACE_MODE: trace_all = data[0];
        REG_TRACED_MASK:     trace_mask = data;
        default: ;
      endcase
    endfunction

    function bit holds_records();
      return (rd_ptr != wr_ptr) || ring_full;
    endfunction

    // Drop the word once the ring is full; flag full when write catches read
    function void store_word(logic [WORD_W-1:0] w);
      if (ring_full) begin
        words_dropped++;
        return;
      end
      ring[wr_ptr] = w;
      wr_ptr = (wr_ptr + 1) % RING_WORDS;
      if (wr_ptr == rd_ptr) ring_full = 1'b1;
    endfunction

    // Advance the mirror by one accepted input word
    function void note_item(logic op, logic [NUM_W-1:0] num,
                            logic [WORD_W-1:0] a1, a2, a3, a4);
      logic [WORD_W-1:0] args [4];
      int unsigned       total;
      read_beat_t        beat;
      items_seen++;
      args = '{a1, a2, a3, a4};
      if (op == OP_RECORD) begin
        if (num == NUM_UNTRACED || !trace_on) return;
        if (!trace_all && !trace_mask[num]) return;
        records_kept++;
        store_word(WORD_W'(num));
        for (int k = 0; k < arg_words(WORD_W'(num)); k++) store_word(args[k]);
        return;
      end
      reads_seen++;
      if (rd_ptr == wr_ptr && !ring_full) begin
        empty_reads++;
        beat = '{data: '0, is_last: 1'b1, is_empty: 1'b1};
        expected_words.push_back(beat);
        return;
      end
      // A read always takes the full record length, even past the write side
      ring_full = 1'b0;
      total = arg_words(ring[rd_ptr]) + 1;
      for (int k = 0; k < total; k++) begin
        beat.data     = ring[rd_ptr];
        beat.is_last  = (k + 1 == total);
        beat.is_empty = 1'b0;
        expected_words.push_back(beat);
        rd_ptr = (rd_ptr + 1) % RING_WORDS;
      end
    endfunction

    // Compare one accepted output word with the oldest expectation
    function void check_word(logic [WORD_W-1:0] w, logic l, logic e);
      read_beat_t want;
      if (expected_words.size() == 0) begin
        failures++;
        $display("%0t: unexpected output word %h last=%b empty=%b", $time, w, l, e);
        return;
      end
      want = expected_words.pop_front();
      words_checked++;
      if (w !== want.data) begin
        failures++;
        $display("%0t: read_word expected %h actual %h", $time, want.data, w);
      end
      if (l !== want.is_last) begin
        failures++;
        $display("%0t: last_word expected %b actual %b", $time, want.is_last, l);
      end
      if (e !== want.is_empty) begin
        failures++;
        $display("%0t: ring_empty expected %b actual %b", $time, want.is_empty, e);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 opcode = OP_RECORD;
  logic [NUM_W-1:0]     syscall_number = '0;
  logic [WORD_W-1:0]    arg_one = '0;
  logic [WORD_W-1:0]    arg_two = '0;
  logic [WORD_W-1:0]    arg_three = '0;
  logic [WORD_W-1:0]    arg_four = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [WORD_W-1:0]    read_word;
  logic                 last_word;
  logic                 ring_empty;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data = '0;

  trace_scoreboard sb;

  // Sender burst state
  int unsigned burst_left = 0;
  bit          sender_gaps = 1'b1;

  // Receiver stall state
  rx_mode_t    rx_mode = RX_FLOW;
  int unsigned rx_cycle = 0;
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;
  int unsigned holds_wanted = 0;

  syscall_trace_recorder i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .syscall_number (syscall_number),
    .arg_one        (arg_one),
    .arg_two        (arg_two),
    .arg_three      (arg_three),
    .arg_four       (arg_four),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .read_word      (read_word),
    .last_word      (last_word),
    .ring_empty     (ring_empty),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check accepted output words, then pick the next stall value
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_word(read_word, last_word, ring_empty);
    if (rx_cycle % 48 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    rx_cycle++;
    if (hold_left == 0 && holds_done < holds_wanted) begin
      hold_left = 200;
      holds_done++;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (rx_mode)
        RX_FLOW:     out_stall <= 1'b0;
        RX_SPARSE:   out_stall <= ($urandom_range(0, 99) < 30);
        RX_PERIODIC: out_stall <= (rx_cycle % 3 == 0);
        default:     out_stall <= ($urandom_range(0, 99) < 75);
      endcase
    end
  end

  // Register value with random upper bits; only bit 0 counts
  function automatic logic [WORD_W-1:0] flag_word(input bit v);
    return {$urandom, 31'($urandom_range(0, 32'h7fff_ffff)), v};
  endfunction

  function automatic logic [WORD_W-1:0] rand_arg();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return WORD_W'($urandom_range(0, 63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  // Offer one input word; gap between bursts, hold until accepted
  task automatic offer_item(input logic op, input logic [NUM_W-1:0] num,
                            input logic [WORD_W-1:0] a1, a2, a3, a4);
    if (sender_gaps && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left != 0) burst_left--;
    in_valid       <= 1'b1;
    opcode         <= op;
    syscall_number <= num;
    arg_one        <= a1;
    arg_two        <= a2;
    arg_three      <= a3;
    arg_four       <= a4;
    do @(posedge clk); while (in_stall);
    sb.note_item(op, num, a1, a2, a3, a4);
  endtask

  task automatic record_call(input logic [NUM_W-1:0] num);
    offer_item(OP_RECORD, num, rand_arg(), rand_arg(), rand_arg(), rand_arg());
  endtask

  // Read request with junk in the ignored fields
  task automatic read_record();
    offer_item(OP_READ, NUM_W'($urandom_range(0, 63)), {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  task automatic mixed_items(input int unsigned count);
    logic [NUM_W-1:0] num;
    repeat (count) begin
      if ($urandom_range(0, 99) < 45) begin
        read_record();
      end else begin
        case ($urandom_range(0, 9))
          0:       num = NUM_UNTRACED;
          1, 2, 3: num = NUM_W'($urandom_range(0, 63));
          default: num = NUM_W'($urandom_range(0, 41));
        endcase
        record_call(num);
      end
    end
  endtask

  // Read until the ring mirror holds nothing more
  task automatic drain_ring();
    int unsigned guard;
    guard = 0;
    while (sb.holds_records() && guard < 64) begin
      read_record();
      guard++;
    end
  endtask

  // Drop valid, wait for every expected word, then let the block go idle
  task automatic settle();
    int unsigned guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.expected_words.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    repeat (12) @(posedge clk);
  endtask

  initial begin
    int unsigned      guard;
    logic [NUM_W-1:0] num;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Tracing off after reset: record ignored, read finds nothing
    offer_item(OP_RECORD, 6'd16, '1, '1, '1, '1);
    read_record();
    settle();

    // Full tracing: every record length, untraced number, unknown number
    write_reg(REG_TRACE_ENABLE, flag_word(1'b1));
    write_reg(REG_FULL_TRACE_MODE, flag_word(1'b1));
    offer_item(OP_RECORD, 6'd0, '0, '0, '0, '0);
    offer_item(OP_RECORD, 6'd16, '1, '1, '1, '1);
    offer_item(OP_RECORD, 6'd35, '0, '1, 64'h8000_0000_0000_0000, 64'h1);
    offer_item(OP_RECORD, NUM_UNTRACED, '1, '1, '1, '1);
    offer_item(OP_RECORD, 6'd63, '1, '1, '1, '1);
    record_call(6'd5);
    record_call(6'd1);
    record_call(6'd4);
    repeat (8) read_record();
    settle();

    // Filtered mode with mask extremes
    write_reg(REG_FULL_TRACE_MODE, flag_word(1'b0));
    write_reg(REG_TRACED_MASK, '0);
    record_call(6'd16);
    settle();
    write_reg(REG_TRACED_MASK, '1);
    offer_item(OP_RECORD, NUM_UNTRACED, '0, '0, '0, '0);
    record_call(6'd37);
    record_call(6'd63);
    repeat (3) read_record();
    settle();

    // Random traffic, full tracing
    write_reg(REG_FULL_TRACE_MODE, flag_word(1'b1));
    mixed_items(50);
    drain_ring();
    settle();

    // Random mask; receiver holds off long enough to back up the input
    write_reg(REG_FULL_TRACE_MODE, flag_word(1'b0));
    write_reg(REG_TRACED_MASK, {$urandom, $urandom});
    holds_wanted++;
    mixed_items(50);
    drain_ring();
    settle();

    // All numbers in the mask, sender back to back
    write_reg(REG_TRACED_MASK, '1);
    sender_gaps = 1'b0;
    mixed_items(30);
    sender_gaps = 1'b1;
    drain_ring();
    settle();

    // Tracing disabled: records ignored, reads come back empty
    write_reg(REG_TRACE_ENABLE, flag_word(1'b0));
    write_reg(REG_FULL_TRACE_MODE, flag_word(1'b1));
    mixed_items(15);
    settle();

    // Overflow: fill the ring past full with long records
    write_reg(REG_TRACE_ENABLE, flag_word(1'b1));
    write_reg(REG_TRACED_MASK, '0);
    guard = 0;
    while (!sb.ring_full && guard < 200) begin
      case ($urandom_range(0, 3))
        0:       num = NUM_W'($urandom_range(0, 41));
        1:       num = 6'd16;
        default: num = 6'd35;
      endcase
      record_call(num);
      guard++;
    end
    repeat (3) record_call(6'd35);
    repeat (45) read_record();
    mixed_items(15);

    settle();
    repeat (20) @(posedge clk);
    if (sb.expected_words.size() != 0) begin
      $display("%0t: %0d expected output words never arrived", $time,
               sb.expected_words.size());
      sb.failures += sb.expected_words.size();
    end
    $display("Run: %0d input words, %0d records traced, %0d reads (%0d on an empty ring)",
             sb.items_seen, sb.records_kept, sb.reads_seen, sb.empty_reads);
    $display("Checked %0d output words; %0d words dropped with the ring full",
             sb.words_checked, sb.words_dropped);
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

### syscall_trace_recorder.f
design/str_pkg.sv
design/syscall_trace_recorder.sv
design/str_checker.sv
sim/testbench.sv
